FILE: rtl/crsc_pkg.sv
package crsc_pkg;

  // Field and register widths.
  localparam int unsigned ADDR_W     = 22;
  localparam int unsigned PIXEL_W    = 16;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned CHIDX_W    = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned FRAME_W    = 12;  // frame_width, crop_width, crop_height
  localparam int unsigned OFS_W      = 11;  // crop_left, crop_top
  localparam int unsigned OUT_REG_W  = 9;   // out_width, out_height

  // Default limits.
  localparam int unsigned MAX_OUT_DIM_DEF   = 256;
  localparam int unsigned MAX_FRAME_DIM_DEF = 2048;

  // Register reset values.
  localparam int unsigned FRAME_W_RST = 320;
  localparam int unsigned CROP_W_RST  = 320;
  localparam int unsigned CROP_H_RST  = 240;
  localparam int unsigned OUT_W_RST   = 96;
  localparam int unsigned OUT_H_RST   = 96;

  // RGB565 unpacking.
  localparam logic [4:0]        RB_MASK   = 5'h1F;
  localparam logic [5:0]        G_MASK    = 6'h3F;
  localparam logic [CHAN_W-1:0] CHAN_BIAS = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH = 3'd0,
    REG_CROP_LEFT   = 3'd1,
    REG_CROP_TOP    = 3'd2,
    REG_CROP_WIDTH  = 3'd3,
    REG_CROP_HEIGHT = 3'd4,
    REG_OUT_WIDTH   = 3'd5,
    REG_OUT_HEIGHT  = 3'd6
  } reg_idx_e;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_PIXEL = 1'b1
  } req_type_e;

  typedef enum logic {
    KIND_ADDR = 1'b0,
    KIND_BYTE = 1'b1
  } kind_e;

  typedef enum logic [CHIDX_W-1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_idx_e;

  typedef enum logic [1:0] {
    MUL_COL,
    MUL_ROW,
    MUL_ADDR
  } mul_sel_e;

  typedef enum logic [1:0] {
    OUT_ADDR,
    OUT_RED,
    OUT_GREEN,
    OUT_BLUE
  } out_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_C,
    S_DIV_C,
    S_MUL_R,
    S_DIV_R,
    S_MUL_A,
    S_SEND_A,
    S_SEND_R,
    S_SEND_G,
    S_SEND_B
  } state_e;

  typedef struct packed {
    logic     start_img;
    logic     step_pix;
    mul_sel_e mul_sel;
    logic     div_load;
    logic     div_step;
    logic     sc_load;
    logic     prod_load;
    logic     out_load;
    out_sel_e out_sel;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/crsc_ctrl.sv
module crsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              req_type_i,
  output logic              in_stall_o,
  input  crsc_pkg::status_t status_i,
  output crsc_pkg::cmd_t    cmd_o
);
  import crsc_pkg::*;

  state_e state_q, state_d;
  logic   take;

  assign in_stall_o = (state_q != S_IDLE);
  assign take       = in_valid_i && (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (take && req_type_i == REQ_START) begin
          state_d = S_MUL_C;
        end else if (take && status_i.busy) begin
          state_d = S_SEND_R;
        end
      end
      S_MUL_C: state_d = S_DIV_C;
      S_DIV_C: begin
        if (status_i.div_done) state_d = S_MUL_R;
      end
      S_MUL_R: state_d = S_DIV_R;
      S_DIV_R: begin
        if (status_i.div_done) state_d = S_MUL_A;
      end
      S_MUL_A: state_d = S_SEND_A;
      S_SEND_A: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      S_SEND_R: begin
        if (status_i.out_free) state_d = S_SEND_G;
      end
      S_SEND_G: begin
        if (status_i.out_free) state_d = S_SEND_B;
      end
      S_SEND_B: begin
        if (status_i.out_free) state_d = status_i.done ? S_IDLE : S_MUL_C;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.mul_sel   = MUL_COL;
    cmd_o.out_sel   = OUT_ADDR;
    cmd_o.start_img = take && (req_type_i == REQ_START);
    cmd_o.step_pix  = take && (req_type_i == REQ_PIXEL) && status_i.busy;
    case (state_q)
      S_MUL_C: begin
        cmd_o.mul_sel  = MUL_COL;
        cmd_o.div_load = 1'b1;
      end
      S_DIV_C, S_DIV_R: cmd_o.div_step = !status_i.div_done;
      S_MUL_R: begin
        cmd_o.sc_load  = 1'b1;
        cmd_o.mul_sel  = MUL_ROW;
        cmd_o.div_load = 1'b1;
      end
      S_MUL_A: begin
        cmd_o.mul_sel   = MUL_ADDR;
        cmd_o.prod_load = 1'b1;
      end
      S_SEND_A: begin
        cmd_o.out_sel  = OUT_ADDR;
        cmd_o.out_load = status_i.out_free;
      end
      S_SEND_R: begin
        cmd_o.out_sel  = OUT_RED;
        cmd_o.out_load = status_i.out_free;
      end
      S_SEND_G: begin
        cmd_o.out_sel  = OUT_GREEN;
        cmd_o.out_load = status_i.out_free;
      end
      S_SEND_B: begin
        cmd_o.out_sel  = OUT_BLUE;
        cmd_o.out_load = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/crsc_datapath.sv
module crsc_datapath #(
  parameter int unsigned MAX_OUT_DIM   = crsc_pkg::MAX_OUT_DIM_DEF,
  parameter int unsigned MAX_FRAME_DIM = crsc_pkg::MAX_FRAME_DIM_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [crsc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [crsc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [crsc_pkg::PIXEL_W-1:0]     pixel_i,
  input  crsc_pkg::cmd_t                   cmd_i,
  output crsc_pkg::status_t                status_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             kind_o,
  output logic [crsc_pkg::ADDR_W-1:0]      read_address_o,
  output logic signed [crsc_pkg::CHAN_W-1:0] channel_value_o,
  output logic [crsc_pkg::CHIDX_W-1:0]     channel_index_o,
  output logic                             last_o
);
  import crsc_pkg::*;

  // effective output size never exceeds the 9-bit register range
  localparam int unsigned EFF_MAX = (MAX_OUT_DIM < 511) ? MAX_OUT_DIM : 511;
  localparam int unsigned ODW     = $clog2(EFF_MAX + 1);
  localparam int unsigned CW      = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;
  localparam int unsigned SCW     = FRAME_W + 1;
  localparam int unsigned PW      = SCW + FRAME_W;
  localparam int unsigned NW      = CW + FRAME_W;
  localparam int unsigned CNTW    = $clog2(NW + 1);
  localparam int unsigned SUMW    = ((PW > ADDR_W) ? PW : ADDR_W) + 1;

  function automatic logic [ODW-1:0] eff_out(input logic [OUT_REG_W-1:0] v);
    if (v == '0) return ODW'(1);
    if (32'(v) > 32'(MAX_OUT_DIM)) return ODW'(MAX_OUT_DIM);
    return ODW'(v);
  endfunction

  function automatic logic [FRAME_W-1:0] sat_frame(input logic [FRAME_W-1:0] v);
    if (32'(v) > 32'(MAX_FRAME_DIM)) return FRAME_W'(MAX_FRAME_DIM);
    return v;
  endfunction

  localparam logic [ODW-1:0] OW_RST = eff_out(OUT_REG_W'(OUT_W_RST));
  localparam logic [ODW-1:0] OH_RST = eff_out(OUT_REG_W'(OUT_H_RST));

  // configuration
  logic [FRAME_W-1:0] fw_q, cw_q, ch_q;
  logic [OFS_W-1:0]   cl_q, ct_q;
  logic [ODW-1:0]     ow_q, oh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FRAME_W'(FRAME_W_RST);
      cl_q <= '0;
      ct_q <= '0;
      cw_q <= FRAME_W'(CROP_W_RST);
      ch_q <= FRAME_W'(CROP_H_RST);
      ow_q <= OW_RST;
      oh_q <= OH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH: fw_q <= sat_frame(cfg_data_i[FRAME_W-1:0]);
        REG_CROP_LEFT:   cl_q <= cfg_data_i[OFS_W-1:0];
        REG_CROP_TOP:    ct_q <= cfg_data_i[OFS_W-1:0];
        REG_CROP_WIDTH:  cw_q <= sat_frame(cfg_data_i[FRAME_W-1:0]);
        REG_CROP_HEIGHT: ch_q <= sat_frame(cfg_data_i[FRAME_W-1:0]);
        REG_OUT_WIDTH:   ow_q <= eff_out(cfg_data_i[OUT_REG_W-1:0]);
        REG_OUT_HEIGHT:  oh_q <= eff_out(cfg_data_i[OUT_REG_W-1:0]);
        default: ;
      endcase
    end
  end

  // output coordinates
  logic [CW-1:0]      col_q, row_q;
  logic               busy_q, done_q;
  logic [PIXEL_W-1:0] pix_q;
  logic [CW:0]        col_inc, row_inc;
  logic               wrap, done;

  always_comb begin
    col_inc = (CW+1)'(col_q) + (CW+1)'(1);
    wrap    = col_inc >= (CW+1)'(ow_q);
    row_inc = (CW+1)'(row_q) + (CW+1)'(wrap);
    done    = row_inc >= (CW+1)'(oh_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (cmd_i.start_img) begin
      col_q  <= '0;
      row_q  <= '0;
      busy_q <= 1'b1;
    end else if (cmd_i.step_pix) begin
      done_q <= done;
      if (done) begin
        col_q  <= '0;
        row_q  <= '0;
        busy_q <= 1'b0;
      end else begin
        col_q <= wrap ? '0 : col_inc[CW-1:0];
        row_q <= row_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_pix) pix_q <= pixel_i;
  end

  // shared multiplier and restoring divider (one quotient bit per cycle)
  logic [SCW-1:0]  quot_ext, sr, sc_q;
  logic [SCW-1:0]  mul_a;
  logic [FRAME_W-1:0] mul_b;
  logic [PW-1:0]   mul, prod_q;
  logic [NW-1:0]   num_q;
  logic [ODW-1:0]  rem_q, den_q;
  logic [CNTW-1:0] cnt_q;
  logic [ODW:0]    shifted, diff;
  logic            fits;

  assign quot_ext = SCW'(num_q[FRAME_W-1:0]);
  assign sr       = SCW'(ct_q) + quot_ext;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_COL: begin
        mul_a = SCW'(col_q);
        mul_b = cw_q;
      end
      MUL_ROW: begin
        mul_a = SCW'(row_q);
        mul_b = ch_q;
      end
      MUL_ADDR: begin
        mul_a = sr;
        mul_b = fw_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul = PW'(mul_a) * PW'(mul_b);
  end

  assign shifted = {rem_q, num_q[NW-1]};
  assign fits    = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_load) begin
      cnt_q <= CNTW'(NW);
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      num_q <= mul[NW-1:0];
      rem_q <= '0;
      den_q <= (cmd_i.mul_sel == MUL_ROW) ? oh_q : ow_q;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[NW-2:0], fits};
      rem_q <= fits ? diff[ODW-1:0] : shifted[ODW-1:0];
    end
    if (cmd_i.sc_load)   sc_q   <= SCW'(cl_q) + quot_ext;
    if (cmd_i.prod_load) prod_q <= mul;
  end

  // channel bytes
  logic [CHAN_W-1:0] red8, grn8, blu8;
  logic [SUMW-1:0]   addr_sum;

  assign red8     = {5'(pix_q >> 11) & RB_MASK, 3'b000} - CHAN_BIAS;
  assign grn8     = {6'(pix_q >> 5) & G_MASK, 2'b00} - CHAN_BIAS;
  assign blu8     = {5'(pix_q) & RB_MASK, 3'b000} - CHAN_BIAS;
  assign addr_sum = SUMW'(prod_q) + SUMW'(sc_q);

  // output register
  logic                out_valid_q, kind_q, last_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [CHAN_W-1:0]   val_q;
  logic [CHIDX_W-1:0]  idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        OUT_ADDR: begin
          kind_q <= KIND_ADDR;
          addr_q <= addr_sum[ADDR_W-1:0];
          val_q  <= '0;
          idx_q  <= CH_RED;
          last_q <= 1'b0;
        end
        OUT_RED: begin
          kind_q <= KIND_BYTE;
          addr_q <= '0;
          val_q  <= red8;
          idx_q  <= CH_RED;
          last_q <= 1'b0;
        end
        OUT_GREEN: begin
          kind_q <= KIND_BYTE;
          addr_q <= '0;
          val_q  <= grn8;
          idx_q  <= CH_GREEN;
          last_q <= 1'b0;
        end
        OUT_BLUE: begin
          kind_q <= KIND_BYTE;
          addr_q <= '0;
          val_q  <= blu8;
          idx_q  <= CH_BLUE;
          last_q <= done_q;
        end
        default: begin
          kind_q <= KIND_BYTE;
          addr_q <= '0;
          val_q  <= '0;
          idx_q  <= CH_RED;
          last_q <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign read_address_o  = addr_q;
  assign channel_value_o = $signed(val_q);
  assign channel_index_o = idx_q;
  assign last_o          = last_q;

  assign status_o.busy     = busy_q;
  assign status_o.done     = done_q;
  assign status_o.div_done = (cnt_q == '0);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule

FILE: rtl/crop_scale_rgb565_to_int8.sv
// Start request: column and row multiply/divide, address multiply, then the
// address request out. Pixel request: red, green and blue bytes, then the next
// address unless the image is done. The input stalls until the last is sent. While
// the output does not stall, the rate is set by the serial divider, one
// quotient bit a cycle, shared by the column and row quotients.
// Reset (async, active low): idle, coordinates zero, registers at defaults.
module crop_scale_rgb565_to_int8 #(
  parameter int unsigned MAX_OUT_DIM   = crsc_pkg::MAX_OUT_DIM_DEF,
  parameter int unsigned MAX_FRAME_DIM = crsc_pkg::MAX_FRAME_DIM_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [crsc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [crsc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input requests
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               req_type_i,
  input  logic [crsc_pkg::PIXEL_W-1:0]       pixel_i,
  // results
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               kind_o,
  output logic [crsc_pkg::ADDR_W-1:0]        read_address_o,
  output logic signed [crsc_pkg::CHAN_W-1:0] channel_value_o,
  output logic [crsc_pkg::CHIDX_W-1:0]       channel_index_o,
  output logic                               last_o
);
  import crsc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Controller: walks multiply / divide / send steps for each request.
  crsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: config registers, coordinates, shared multiplier, serial
  // divider and the output register that decouples the result side.
  crsc_datapath #(
    .MAX_OUT_DIM   (MAX_OUT_DIM),
    .MAX_FRAME_DIM (MAX_FRAME_DIM)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .pixel_i         (pixel_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .read_address_o  (read_address_o),
    .channel_value_o (channel_value_o),
    .channel_index_o (channel_index_o),
    .last_o          (last_o)
  );

  // A result is only loaded when the output slot is free or draining.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> status.out_free)
    else $error("output loaded over a pending result");

  // A start request always leads into the address computation.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && req_type_i == REQ_START |=> in_stall_o && status.busy)
    else $error("start request did not begin an image");

  // The divider is never stepped past its last quotient bit.
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> !status.div_done)
    else $error("divider stepped after completion");

  // The last flag only rides on a blue byte.
  a_last_blue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load && cmd.out_sel != OUT_BLUE |=> !last_o)
    else $error("last set on a non-blue result");

endmodule
